>>> rtl/clt_pkg.sv
// ----------------------------------------------------------------------------
// clt_pkg
// shared types and codes of the counted loop tape machine
// ----------------------------------------------------------------------------
`default_nettype none

package clt_pkg;

  localparam int PROG_WORDS = 1024;
  localparam int PA_W       = 10;
  localparam int PC_W       = 11;
  localparam int LEN_W      = 11;
  localparam int OP_W       = 4;
  localparam int OPND_W     = 64;
  localparam int BYTE_W     = 8;
  localparam int HALT_W     = 3;
  localparam int ACT_W      = 2;

  localparam logic [ACT_W-1:0] ACT_LOAD    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_RESTART = 2'd1;
  localparam logic [ACT_W-1:0] ACT_STEP    = 2'd2;

  localparam logic [OP_W-1:0] OP_LEFT   = 4'd0;
  localparam logic [OP_W-1:0] OP_RIGHT  = 4'd1;
  localparam logic [OP_W-1:0] OP_ADD    = 4'd2;
  localparam logic [OP_W-1:0] OP_SUB    = 4'd3;
  localparam logic [OP_W-1:0] OP_SET    = 4'd4;
  localparam logic [OP_W-1:0] OP_GOTO   = 4'd5;
  localparam logic [OP_W-1:0] OP_OUTPUT = 4'd6;
  localparam logic [OP_W-1:0] OP_PRINT  = 4'd7;
  localparam logic [OP_W-1:0] OP_READ   = 4'd8;
  localparam logic [OP_W-1:0] OP_ZERO   = 4'd9;
  localparam logic [OP_W-1:0] OP_LSTART = 4'd10;
  localparam logic [OP_W-1:0] OP_LEND   = 4'd11;

  localparam logic [HALT_W-1:0] HALT_RUN        = 3'd0;
  localparam logic [HALT_W-1:0] HALT_DONE       = 3'd1;
  localparam logic [HALT_W-1:0] HALT_PTR_UNDER  = 3'd2;
  localparam logic [HALT_W-1:0] HALT_TAPE_OVER  = 3'd3;
  localparam logic [HALT_W-1:0] HALT_VAL_UNDER  = 3'd4;
  localparam logic [HALT_W-1:0] HALT_LOOP_UNDER = 3'd5;
  localparam logic [HALT_W-1:0] HALT_LOOP_OVER  = 3'd6;

  typedef struct packed {
    logic capture;
    logic execute;
  } clt_cmd_t;

endpackage

`default_nettype wire

>>> rtl/clt_ctrl.sv
// ----------------------------------------------------------------------------
// clt_ctrl
// beat sequencer: capture an item, execute it, hold the result beat
// ----------------------------------------------------------------------------
`default_nettype none

module clt_ctrl
  import clt_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     s_valid_i,
  output logic          s_ready_o,
  output logic          m_valid_o,
  input  wire logic     m_ready_i,
  output clt_cmd_t      cmd_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic st_q, st_d;
  logic ovalid_q, ovalid_d;
  logic accept;

  assign s_ready_o = (st_q == S_IDLE) && (!ovalid_q || m_ready_i);
  assign accept    = s_valid_i && s_ready_o;
  assign m_valid_o = ovalid_q;

  assign cmd_o.capture = accept;
  assign cmd_o.execute = (st_q == S_EXEC);

  always_comb begin
    st_d = st_q;
    case (st_q)
      S_IDLE:  if (accept) st_d = S_EXEC;
      S_EXEC:  st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_comb begin
    ovalid_d = ovalid_q;
    if (st_q == S_EXEC) begin
      ovalid_d = 1'b1;
    end else if (m_ready_i) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= S_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      st_q     <= st_d;
      ovalid_q <= ovalid_d;
    end
  end

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> st_q == S_EXEC)
    else $error("accepted beat not executed");

  a_exec_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == S_EXEC |=> (st_q == S_IDLE) && ovalid_q)
    else $error("execute did not produce a result beat");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && !m_ready_i |-> !s_ready_o)
    else $error("input taken while result beat is stuck");

endmodule

`default_nettype wire

>>> rtl/clt_datapath.sv
// ----------------------------------------------------------------------------
// clt_datapath
// program and tape memories, run registers, loop stack and result register
// ----------------------------------------------------------------------------
`default_nettype none

module clt_datapath
  import clt_pkg::*;
#(
  parameter int TAPE_CELLS = 256,
  parameter int LOOP_NEST  = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire clt_cmd_t          cmd_i,
  input  wire logic              cfg_wr_en_i,
  input  wire logic [LEN_W-1:0]  cfg_wr_data_i,
  input  wire logic [ACT_W-1:0]  action_i,
  input  wire logic [PA_W-1:0]   load_address_i,
  input  wire logic [OP_W-1:0]   opcode_i,
  input  wire logic [OPND_W-1:0] operand_i,
  input  wire logic [PA_W-1:0]   jump_target_i,
  input  wire logic [BYTE_W-1:0] in_byte_i,
  input  wire logic              in_eof_i,
  output logic                   out_valid_o,
  output logic [BYTE_W-1:0]      out_byte_o,
  output logic                   input_used_o,
  output logic [HALT_W-1:0]      run_state_o
);

  localparam int HW = $clog2(TAPE_CELLS);
  localparam int DW = $clog2(LOOP_NEST + 1);
  localparam int SW = (LOOP_NEST > 1) ? $clog2(LOOP_NEST) : 1;

  // run registers
  logic [LEN_W-1:0]      len_q;
  logic [PC_W-1:0]       pc_q, pc_d;
  logic [HW-1:0]         head_q, head_d;
  logic [HW-1:0]         emit_q, emit_d;
  logic                  emitting_q, emitting_d;
  logic [DW-1:0]         depth_q, depth_d;
  logic [HALT_W-1:0]     halt_q, halt_d;
  logic [TAPE_CELLS-1:0] nz_q, nz_d;

  // captured item
  logic [ACT_W-1:0]  act_q;
  logic [PA_W-1:0]   la_q;
  logic [OP_W-1:0]   op_in_q;
  logic [OPND_W-1:0] opnd_in_q;
  logic [PA_W-1:0]   jt_q;
  logic [BYTE_W-1:0] byte_q;
  logic              eof_q;

  // memories
  logic [OP_W-1:0]   prog_op_mem   [PROG_WORDS];
  logic [OPND_W-1:0] prog_opnd_mem [PROG_WORDS];
  logic [PA_W-1:0]   prog_tgt_mem  [PROG_WORDS];
  logic [OPND_W-1:0] tape_mem      [TAPE_CELLS];
  logic [OP_W-1:0]   op_rd_q;
  logic [OPND_W-1:0] opnd_rd_q;
  logic [PA_W-1:0]   tgt_rd_q;
  logic [OPND_W-1:0] tape_hd_q;
  logic [OPND_W-1:0] tape_em_q;

  // loop stack
  logic [PA_W-1:0]   ret_q [LOOP_NEST];
  logic [OPND_W-1:0] rem_q [LOOP_NEST];

  // result register
  logic              ov_q, ov_d;
  logic [BYTE_W-1:0] ob_q, ob_d;
  logic              used_q, used_d;
  logic [HALT_W-1:0] rs_q;

  logic [LEN_W-1:0]      len_eff;
  logic                  scan_sel;
  logic [HW-1:0]         tidx;
  logic [OPND_W-1:0]     cur_val;
  logic [TAPE_CELLS-1:0] above;
  logic                  nz_above;
  logic [SW-1:0]         top;
  logic [SW-1:0]         slot;
  logic [PC_W-1:0]       next_pc;
  logic [HALT_W-1:0]     err;
  logic                  prog_we, tape_we, push, dec;
  logic [OPND_W-1:0]     tape_wd;

  // only an output instruction continues a scan, everything else works at the head
  assign scan_sel = emitting_q && (op_rd_q == OP_OUTPUT);
  assign tidx     = scan_sel ? emit_q : head_q;
  assign len_eff  = (len_q > LEN_W'(PROG_WORDS)) ? LEN_W'(PROG_WORDS) : len_q;
  assign cur_val  = nz_q[tidx] ? (scan_sel ? tape_em_q : tape_hd_q) : '0;
  assign above    = nz_q >> tidx;
  assign nz_above = |above[TAPE_CELLS-1:1];
  assign top      = SW'(depth_q - DW'(1));
  assign slot     = depth_q[SW-1:0];

  always_comb begin
    pc_d       = pc_q;
    head_d     = head_q;
    emit_d     = emit_q;
    emitting_d = emitting_q;
    depth_d    = depth_q;
    halt_d     = halt_q;
    nz_d       = nz_q;
    next_pc    = pc_q + PC_W'(1);
    err        = HALT_RUN;
    prog_we    = 1'b0;
    tape_we    = 1'b0;
    tape_wd    = cur_val;
    push       = 1'b0;
    dec        = 1'b0;
    ov_d       = 1'b0;
    ob_d       = '0;
    used_d     = 1'b0;
    if (cmd_i.execute) begin
      case (act_q)
        ACT_LOAD: prog_we = 1'b1;
        ACT_RESTART: begin
          nz_d       = '0;
          head_d     = '0;
          pc_d       = '0;
          depth_d    = '0;
          emit_d     = '0;
          emitting_d = 1'b0;
          halt_d     = HALT_RUN;
        end
        ACT_STEP: begin
          if (halt_q == HALT_RUN) begin
            if (pc_q >= len_eff) begin
              halt_d = HALT_DONE;
            end else begin
              case (op_rd_q)
                OP_LEFT: begin
                  if (head_q == '0) err = HALT_PTR_UNDER;
                  else head_d = head_q - HW'(1);
                end
                OP_RIGHT: begin
                  if (head_q == HW'(TAPE_CELLS - 1)) err = HALT_TAPE_OVER;
                  else head_d = head_q + HW'(1);
                end
                OP_ADD: begin
                  tape_we = 1'b1;
                  tape_wd = cur_val + OPND_W'(1);
                end
                OP_SUB: begin
                  if (cur_val == '0) begin
                    err = HALT_VAL_UNDER;
                  end else begin
                    tape_we = 1'b1;
                    tape_wd = cur_val - OPND_W'(1);
                  end
                end
                OP_SET: begin
                  tape_we = 1'b1;
                  tape_wd = opnd_rd_q;
                end
                OP_GOTO: begin
                  if (opnd_rd_q >= OPND_W'(TAPE_CELLS)) err = HALT_TAPE_OVER;
                  else head_d = opnd_rd_q[HW-1:0];
                end
                OP_OUTPUT: begin
                  ov_d = 1'b1;
                  ob_d = cur_val[BYTE_W-1:0];
                  if (nz_above) begin
                    emitting_d = 1'b1;
                    emit_d     = tidx + HW'(1);
                    next_pc    = pc_q;
                  end else begin
                    emitting_d = 1'b0;
                    emit_d     = '0;
                  end
                end
                OP_PRINT: begin
                  ov_d = 1'b1;
                  ob_d = cur_val[BYTE_W-1:0];
                end
                OP_READ: begin
                  used_d  = 1'b1;
                  tape_we = 1'b1;
                  tape_wd = eof_q ? '0 : OPND_W'(byte_q);
                end
                OP_ZERO: begin
                  tape_we = 1'b1;
                  tape_wd = '0;
                end
                OP_LSTART: begin
                  if (opnd_rd_q == '0) begin
                    next_pc = PC_W'(tgt_rd_q) + PC_W'(1);
                  end else if (depth_q >= DW'(LOOP_NEST)) begin
                    err = HALT_LOOP_OVER;
                  end else begin
                    push    = 1'b1;
                    depth_d = depth_q + DW'(1);
                  end
                end
                OP_LEND: begin
                  if (depth_q == '0) begin
                    err = HALT_LOOP_UNDER;
                  end else if (rem_q[top] <= OPND_W'(1)) begin
                    depth_d = depth_q - DW'(1);
                  end else begin
                    dec     = 1'b1;
                    next_pc = PC_W'(ret_q[top]) + PC_W'(1);
                  end
                end
                default: ;
              endcase
              if (tape_we) nz_d[tidx] = |tape_wd;
              if (err == HALT_RUN) begin
                pc_d = next_pc;
                if (next_pc >= len_eff) halt_d = HALT_DONE;
              end else begin
                halt_d = err;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q      <= '0;
      pc_q       <= '0;
      head_q     <= '0;
      emit_q     <= '0;
      emitting_q <= 1'b0;
      depth_q    <= '0;
      halt_q     <= HALT_RUN;
      nz_q       <= '0;
    end else begin
      if (cfg_wr_en_i) len_q <= cfg_wr_data_i;
      pc_q       <= pc_d;
      head_q     <= head_d;
      emit_q     <= emit_d;
      emitting_q <= emitting_d;
      depth_q    <= depth_d;
      halt_q     <= halt_d;
      nz_q       <= nz_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q     <= action_i;
      la_q      <= load_address_i;
      op_in_q   <= opcode_i;
      opnd_in_q <= operand_i;
      jt_q      <= jump_target_i;
      byte_q    <= in_byte_i;
      eof_q     <= in_eof_i;
      op_rd_q   <= prog_op_mem[pc_q[PA_W-1:0]];
      opnd_rd_q <= prog_opnd_mem[pc_q[PA_W-1:0]];
      tgt_rd_q  <= prog_tgt_mem[pc_q[PA_W-1:0]];
      tape_hd_q <= tape_mem[head_q];
      tape_em_q <= tape_mem[emit_q];
    end
    if (prog_we) begin
      prog_op_mem[la_q]   <= op_in_q;
      prog_opnd_mem[la_q] <= opnd_in_q;
      prog_tgt_mem[la_q]  <= jt_q;
    end
    if (tape_we) tape_mem[tidx] <= tape_wd;
    if (push) begin
      ret_q[slot] <= pc_q[PA_W-1:0];
      rem_q[slot] <= opnd_rd_q;
    end
    if (dec) rem_q[top] <= rem_q[top] - OPND_W'(1);
    if (cmd_i.execute) begin
      ov_q   <= ov_d;
      ob_q   <= ob_d;
      used_q <= used_d;
      rs_q   <= halt_d;
    end
  end

  assign out_valid_o  = ov_q;
  assign out_byte_o   = ob_q;
  assign input_used_o = used_q;
  assign run_state_o  = rs_q;

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DW'(LOOP_NEST))
    else $error("loop stack depth out of range");

  a_halt_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.execute && (halt_q != HALT_RUN) && (act_q == ACT_STEP)
    |=> $stable(pc_q) && $stable(head_q) && $stable(nz_q))
    else $error("halted machine changed state");

  a_emit_keeps_pc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.execute && (act_q == ACT_STEP) && (op_rd_q == OP_OUTPUT) && emitting_d
    && (halt_d == HALT_RUN) |=> $stable(pc_q))
    else $error("pc advanced during output scan");

endmodule

`default_nettype wire

>>> rtl/counted_loop_tape_machine.sv
// ----------------------------------------------------------------------------
// counted_loop_tape_machine
// tape machine with 64-bit cells, counted loops and a loaded program
// ----------------------------------------------------------------------------
// Every input beat (load word, restart, or step) gives exactly one result
// beat. The accept cycle reads the program word at the pc and the tape cells
// at the head and at the output scan position from their block memories, the
// next cycle executes the instruction and writes the tape, registers and the
// result beat. The next item is taken once the previous item has executed
// and the result slot is free, so no new item is accepted while one is in
// execution. The tape holds TAPE_CELLS cells; a per-cell nonzero bit vector,
// cleared at once by reset or restart, stands for the zeroed tape and drives
// the output scan's nonzero-above check, so no clearing pass is needed. The
// loop stack holds LOOP_NEST entries. The program store holds 1024 words and
// is not cleared.
`default_nettype none

module counted_loop_tape_machine
  import clt_pkg::*;
#(
  parameter int TAPE_CELLS = 256,
  parameter int LOOP_NEST  = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // configuration: program_length
  input  wire logic             cfg_wr_en_i,
  input  wire logic [LEN_W-1:0] cfg_wr_data_i,
  // input beats
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  // load_address[9:0], opcode[13:10], operand[77:14], jump_target[87:78],
  // in_byte[95:88], in_eof[96], zero fill above
  input  wire logic [103:0]     s_axis_tdata,
  // action[1:0]
  input  wire logic [1:0]       s_axis_tuser,
  // result beats
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  // out_valid[0], out_byte[8:1], input_used[9], run_state[12:10], zero fill
  output logic [15:0]           m_axis_tdata
);

  clt_cmd_t          cmd;
  logic              out_valid;
  logic [BYTE_W-1:0] out_byte;
  logic              input_used;
  logic [HALT_W-1:0] run_state;

  // sequencer: accept, execute, hold result
  clt_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .cmd_o     (cmd)
  );

  // memories, run state and instruction execution
  clt_datapath #(
    .TAPE_CELLS (TAPE_CELLS),
    .LOOP_NEST  (LOOP_NEST)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .cfg_wr_en_i    (cfg_wr_en_i),
    .cfg_wr_data_i  (cfg_wr_data_i),
    .action_i       (s_axis_tuser),
    .load_address_i (s_axis_tdata[9:0]),
    .opcode_i       (s_axis_tdata[13:10]),
    .operand_i      (s_axis_tdata[77:14]),
    .jump_target_i  (s_axis_tdata[87:78]),
    .in_byte_i      (s_axis_tdata[95:88]),
    .in_eof_i       (s_axis_tdata[96]),
    .out_valid_o    (out_valid),
    .out_byte_o     (out_byte),
    .input_used_o   (input_used),
    .run_state_o    (run_state)
  );

  // pack result fields, lowest field first
  assign m_axis_tdata = {3'b000, run_state, input_used, out_byte, out_valid};

endmodule

`default_nettype wire
